@@ hdl/tekd_pkg.sv @@
package tekd_pkg;

    localparam int unsigned POS_W = 5;
    localparam int unsigned BYTE_W = 8;

    // Parse positions
    localparam logic [POS_W-1:0] P_IDLE = 5'd0;
    localparam logic [POS_W-1:0] P_ESC  = 5'd1;
    localparam logic [POS_W-1:0] P_CSI  = 5'd2;
    localparam logic [POS_W-1:0] P_SS3  = 5'd3;
    localparam logic [POS_W-1:0] P_CSI2 = 5'd4;
    localparam logic [POS_W-1:0] P_D1   = 5'd5;
    localparam logic [POS_W-1:0] P_D15  = 5'd6;
    localparam logic [POS_W-1:0] P_D17  = 5'd7;
    localparam logic [POS_W-1:0] P_D18  = 5'd8;
    localparam logic [POS_W-1:0] P_D19  = 5'd9;
    localparam logic [POS_W-1:0] P_D2   = 5'd10;
    localparam logic [POS_W-1:0] P_D20  = 5'd11;
    localparam logic [POS_W-1:0] P_D21  = 5'd12;
    localparam logic [POS_W-1:0] P_D23  = 5'd13;
    localparam logic [POS_W-1:0] P_D24  = 5'd14;
    localparam logic [POS_W-1:0] P_D3   = 5'd15;
    localparam logic [POS_W-1:0] P_D4   = 5'd16;
    localparam logic [POS_W-1:0] P_D5   = 5'd17;
    localparam logic [POS_W-1:0] P_D6   = 5'd18;

    // Special key numbers
    localparam logic [BYTE_W-1:0] K_UP      = 8'd0;
    localparam logic [BYTE_W-1:0] K_DOWN    = 8'd1;
    localparam logic [BYTE_W-1:0] K_LEFT    = 8'd2;
    localparam logic [BYTE_W-1:0] K_RIGHT   = 8'd3;
    localparam logic [BYTE_W-1:0] K_PGUP    = 8'd4;
    localparam logic [BYTE_W-1:0] K_PGDOWN  = 8'd5;
    localparam logic [BYTE_W-1:0] K_HOME    = 8'd6;
    localparam logic [BYTE_W-1:0] K_END     = 8'd7;
    localparam logic [BYTE_W-1:0] K_INSERT  = 8'd8;
    localparam logic [BYTE_W-1:0] K_DELETE  = 8'd9;
    localparam logic [BYTE_W-1:0] K_SHUP    = 8'd10;
    localparam logic [BYTE_W-1:0] K_SHDOWN  = 8'd11;
    localparam logic [BYTE_W-1:0] K_SHLEFT  = 8'd12;
    localparam logic [BYTE_W-1:0] K_SHRIGHT = 8'd13;
    localparam logic [BYTE_W-1:0] K_CTUP    = 8'd14;
    localparam logic [BYTE_W-1:0] K_CTDOWN  = 8'd15;
    localparam logic [BYTE_W-1:0] K_CTLEFT  = 8'd16;
    localparam logic [BYTE_W-1:0] K_CTRIGHT = 8'd17;
    localparam logic [BYTE_W-1:0] K_F1      = 8'd18;
    localparam logic [BYTE_W-1:0] K_F5      = 8'd22;
    localparam logic [BYTE_W-1:0] K_F6      = 8'd23;
    localparam logic [BYTE_W-1:0] K_F7      = 8'd24;
    localparam logic [BYTE_W-1:0] K_F8      = 8'd25;
    localparam logic [BYTE_W-1:0] K_F9      = 8'd26;
    localparam logic [BYTE_W-1:0] K_F10     = 8'd27;
    localparam logic [BYTE_W-1:0] K_F11     = 8'd28;
    localparam logic [BYTE_W-1:0] K_F12     = 8'd29;
    localparam logic [BYTE_W-1:0] K_DBLESC  = 8'd30;
    localparam logic [BYTE_W-1:0] K_NUMPAD5 = 8'd31;

    localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h1B;

    typedef struct packed {
        logic              emit;
        logic              is_special;
        logic [BYTE_W-1:0] key_index;
        logic [POS_W-1:0]  next_pos;
    } tekd_dec_t;

endpackage

@@ hdl/tekd_decode.sv @@
module tekd_decode (
    input  logic [tekd_pkg::POS_W-1:0]  pos,
    input  logic [tekd_pkg::BYTE_W-1:0] in_byte,
    output tekd_pkg::tekd_dec_t         dec
);
    import tekd_pkg::*;

    always_comb begin
        // Default: emit the byte raw and drop back to idle
        dec.emit       = 1'b1;
        dec.is_special = 1'b0;
        dec.key_index  = in_byte;
        dec.next_pos   = P_IDLE;

        unique case (pos)
            P_ESC: begin
                if (in_byte == "[") begin
                    dec.emit = 1'b0;
                    dec.next_pos = P_CSI;
                end else if (in_byte == "O") begin
                    dec.emit = 1'b0;
                    dec.next_pos = P_SS3;
                end else if (in_byte == ESC_BYTE) begin
                    dec.is_special = 1'b1;
                    dec.key_index = K_DBLESC;
                end
            end
            P_SS3: begin
                if (in_byte >= "P" && in_byte <= "S") begin
                    dec.is_special = 1'b1;
                    dec.key_index = K_F1 + (in_byte - 8'("P"));
                end
            end
            P_CSI: begin
                case (in_byte)
                    "A": begin dec.is_special = 1'b1; dec.key_index = K_UP;    end
                    "B": begin dec.is_special = 1'b1; dec.key_index = K_DOWN;  end
                    "D": begin dec.is_special = 1'b1; dec.key_index = K_LEFT;  end
                    "C": begin dec.is_special = 1'b1; dec.key_index = K_RIGHT; end
                    "H": begin dec.is_special = 1'b1; dec.key_index = K_HOME;  end
                    "F": begin dec.is_special = 1'b1; dec.key_index = K_END;   end
                    "E", "G": begin
                        dec.is_special = 1'b1;
                        dec.key_index = K_NUMPAD5;
                    end
                    "1": begin dec.emit = 1'b0; dec.next_pos = P_D1;   end
                    "2": begin dec.emit = 1'b0; dec.next_pos = P_D2;   end
                    "3": begin dec.emit = 1'b0; dec.next_pos = P_D3;   end
                    "4": begin dec.emit = 1'b0; dec.next_pos = P_D4;   end
                    "5": begin dec.emit = 1'b0; dec.next_pos = P_D5;   end
                    "6": begin dec.emit = 1'b0; dec.next_pos = P_D6;   end
                    "[": begin dec.emit = 1'b0; dec.next_pos = P_CSI2; end
                    default: ;
                endcase
            end
            P_CSI2: begin
                if (in_byte >= "A" && in_byte <= "E") begin
                    dec.is_special = 1'b1;
                    dec.key_index = K_F1 + (in_byte - 8'("A"));
                end
            end
            P_D1: begin
                case (in_byte)
                    "~": begin dec.is_special = 1'b1; dec.key_index = K_HOME; end
                    "5": begin dec.emit = 1'b0; dec.next_pos = P_D15; end
                    "7": begin dec.emit = 1'b0; dec.next_pos = P_D17; end
                    "8": begin dec.emit = 1'b0; dec.next_pos = P_D18; end
                    "9": begin dec.emit = 1'b0; dec.next_pos = P_D19; end
                    default: ;
                endcase
            end
            P_D2: begin
                case (in_byte)
                    "~": begin dec.is_special = 1'b1; dec.key_index = K_INSERT;  end
                    "A": begin dec.is_special = 1'b1; dec.key_index = K_SHUP;    end
                    "B": begin dec.is_special = 1'b1; dec.key_index = K_SHDOWN;  end
                    "D": begin dec.is_special = 1'b1; dec.key_index = K_SHLEFT;  end
                    "C": begin dec.is_special = 1'b1; dec.key_index = K_SHRIGHT; end
                    "0": begin dec.emit = 1'b0; dec.next_pos = P_D20; end
                    "1": begin dec.emit = 1'b0; dec.next_pos = P_D21; end
                    "3": begin dec.emit = 1'b0; dec.next_pos = P_D23; end
                    "4": begin dec.emit = 1'b0; dec.next_pos = P_D24; end
                    default: ;
                endcase
            end
            P_D5: begin
                case (in_byte)
                    "~": begin dec.is_special = 1'b1; dec.key_index = K_PGUP;    end
                    "A": begin dec.is_special = 1'b1; dec.key_index = K_CTUP;    end
                    "B": begin dec.is_special = 1'b1; dec.key_index = K_CTDOWN;  end
                    "D": begin dec.is_special = 1'b1; dec.key_index = K_CTLEFT;  end
                    "C": begin dec.is_special = 1'b1; dec.key_index = K_CTRIGHT; end
                    default: ;
                endcase
            end
            P_D15, P_D17, P_D18, P_D19, P_D20, P_D21, P_D23, P_D24,
            P_D3, P_D4, P_D6: begin
                // Positions that only accept a closing tilde
                if (in_byte == "~") begin
                    dec.is_special = 1'b1;
                    unique case (pos)
                        P_D15:   dec.key_index = K_F5;
                        P_D17:   dec.key_index = K_F6;
                        P_D18:   dec.key_index = K_F7;
                        P_D19:   dec.key_index = K_F8;
                        P_D20:   dec.key_index = K_F9;
                        P_D21:   dec.key_index = K_F10;
                        P_D23:   dec.key_index = K_F11;
                        P_D24:   dec.key_index = K_F12;
                        P_D3:    dec.key_index = K_DELETE;
                        P_D4:    dec.key_index = K_END;
                        default: dec.key_index = K_PGDOWN;
                    endcase
                end
            end
            default: begin
                // Idle, and any unused position code
                if (in_byte == ESC_BYTE) begin
                    dec.emit = 1'b0;
                    dec.next_pos = P_ESC;
                end
            end
        endcase
    end

endmodule

@@ hdl/tekd_result_reg.sv @@
module tekd_result_reg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        load,
    input  tekd_pkg::tekd_dec_t         dec,
    input  logic                        m_ready,
    output logic                        m_valid,
    output logic                        m_is_special,
    output logic [tekd_pkg::BYTE_W-1:0] m_key_index,
    output logic                        can_take
);
    import tekd_pkg::*;

    logic              valid_reg;
    logic              valid_next;
    logic              special_reg;
    logic [BYTE_W-1:0] key_reg;

    // Take a new request whenever the held result is gone or leaves this cycle
    assign can_take = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            special_reg <= dec.is_special;
            key_reg     <= dec.key_index;
        end
    end

    assign m_valid      = valid_reg;
    assign m_is_special = special_reg;
    assign m_key_index  = key_reg;

endmodule

@@ hdl/terminal_escape_key_decoder.sv @@
// A byte that completes a key or is passed raw shows on m_ in the cycle after it is accepted.
// Throughput: 1 byte per cycle unless m_ready stalls the output; decode is combinational
// and the result register frees itself in the same cycle that its result is taken.
// Prefix bytes (ESC, '[', 'O', digits) yield no result and only advance the parse position.
// Reset (aresetn low, synchronous): parse position idle, result register empty.
module terminal_escape_key_decoder (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [tekd_pkg::BYTE_W-1:0] s_in_byte,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_is_special,
    output logic [tekd_pkg::BYTE_W-1:0] m_key_index
);
    import tekd_pkg::*;

    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    tekd_dec_t        dec;
    logic             accept;
    logic             can_take;

    tekd_decode u_decode (
        .pos     (pos_reg),
        .in_byte (s_in_byte),
        .dec     (dec)
    );

    assign s_ready = can_take;
    assign accept  = s_valid && s_ready;

    always_comb begin
        pos_next = pos_reg;
        if (accept) begin
            pos_next = dec.next_pos;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= P_IDLE;
        end else begin
            pos_reg <= pos_next;
        end
    end

    tekd_result_reg u_result (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .load         (accept && dec.emit),
        .dec          (dec),
        .m_ready      (m_ready),
        .m_valid      (m_valid),
        .m_is_special (m_is_special),
        .m_key_index  (m_key_index),
        .can_take     (can_take)
    );

    // A raw non-ESC byte taken while idle comes straight back out
    a_idle_raw: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pos_reg == P_IDLE && s_in_byte != ESC_BYTE
        |=> m_valid && !m_is_special && m_key_index == $past(s_in_byte))
        else $error("idle raw byte not passed through");

    // Any emission drops the parse back to idle
    a_emit_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && dec.emit |=> pos_reg == P_IDLE)
        else $error("parse position not idle after emission");

    // ESC from idle produces no result and enters the escape position
    a_esc_enter: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && pos_reg == P_IDLE && s_in_byte == ESC_BYTE
        |=> pos_reg == P_ESC && (!m_valid || $past(m_valid && !m_ready)))
        else $error("ESC from idle mishandled");

    // Special key numbers stay within the key list
    a_special_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_special |-> m_key_index <= K_NUMPAD5)
        else $error("special key number out of range");

endmodule

@@ sim/terminal_escape_key_decoder_tb.sv @@
`timescale 1ns / 1ps

module terminal_escape_key_decoder_tb;
    import tekd_pkg::*;

    typedef struct packed {
        logic              special;
        logic [BYTE_W-1:0] key;
    } key_result_t;

    class key_scoreboard;
        logic [POS_W-1:0] pos;
        key_result_t      expected_keys[$];
        int               errors;
        int               decoded;
        int               raws;
        logic [31:0]      seen_keys;

        function new();
            pos = P_IDLE;
            errors = 0;
            decoded = 0;
            raws = 0;
            seen_keys = '0;
        endfunction

        task report(string msg);
            if (errors < 100) begin
                $display("MISMATCH @%0t: %s", $time, msg);
            end
            errors++;
        endtask

        function key_result_t spec(logic [BYTE_W-1:0] k);
            key_result_t r;
            r.special = 1'b1;
            r.key = k;
            return r;
        endfunction

        // Walk one byte through the parse positions; returns 1 when a key comes out.
        function bit decode_byte(logic [BYTE_W-1:0] b, output key_result_t r);
            logic [POS_W-1:0]  nxt;
            logic [BYTE_W-1:0] tilde_key;
            bit                tilde_pos;
            bit                hit;
            nxt = P_IDLE;
            hit = 1'b1;
            r.special = 1'b0;
            r.key = b;
            tilde_pos = 1'b1;
            case (pos)
                P_D15: tilde_key = K_F5;
                P_D17: tilde_key = K_F6;
                P_D18: tilde_key = K_F7;
                P_D19: tilde_key = K_F8;
                P_D20: tilde_key = K_F9;
                P_D21: tilde_key = K_F10;
                P_D23: tilde_key = K_F11;
                P_D24: tilde_key = K_F12;
                P_D3:  tilde_key = K_DELETE;
                P_D4:  tilde_key = K_END;
                P_D6:  tilde_key = K_PGDOWN;
                default: begin
                    tilde_key = '0;
                    tilde_pos = 1'b0;
                end
            endcase
            if (tilde_pos) begin
                if (b == "~") r = spec(tilde_key);
            end else begin
                case (pos)
                    P_ESC: begin
                        if (b == "[") nxt = P_CSI;
                        else if (b == "O") nxt = P_SS3;
                        else if (b == ESC_BYTE) r = spec(K_DBLESC);
                    end
                    P_SS3: begin
                        if (b >= "P" && b <= "S") r = spec(8'(K_F1 + b - "P"));
                    end
                    P_CSI2: begin
                        if (b >= "A" && b <= "E") r = spec(8'(K_F1 + b - "A"));
                    end
                    P_CSI: begin
                        case (b)
                            "A": r = spec(K_UP);
                            "B": r = spec(K_DOWN);
                            "D": r = spec(K_LEFT);
                            "C": r = spec(K_RIGHT);
                            "H": r = spec(K_HOME);
                            "F": r = spec(K_END);
                            "E", "G": r = spec(K_NUMPAD5);
                            "1": nxt = P_D1;
                            "2": nxt = P_D2;
                            "3": nxt = P_D3;
                            "4": nxt = P_D4;
                            "5": nxt = P_D5;
                            "6": nxt = P_D6;
                            "[": nxt = P_CSI2;
                            default: ;
                        endcase
                    end
                    P_D1: begin
                        case (b)
                            "~": r = spec(K_HOME);
                            "5": nxt = P_D15;
                            "7": nxt = P_D17;
                            "8": nxt = P_D18;
                            "9": nxt = P_D19;
                            default: ;
                        endcase
                    end
                    P_D2: begin
                        case (b)
                            "~": r = spec(K_INSERT);
                            "A": r = spec(K_SHUP);
                            "B": r = spec(K_SHDOWN);
                            "D": r = spec(K_SHLEFT);
                            "C": r = spec(K_SHRIGHT);
                            "0": nxt = P_D20;
                            "1": nxt = P_D21;
                            "3": nxt = P_D23;
                            "4": nxt = P_D24;
                            default: ;
                        endcase
                    end
                    P_D5: begin
                        case (b)
                            "~": r = spec(K_PGUP);
                            "A": r = spec(K_CTUP);
                            "B": r = spec(K_CTDOWN);
                            "D": r = spec(K_CTLEFT);
                            "C": r = spec(K_CTRIGHT);
                            default: ;
                        endcase
                    end
                    default: begin
                        if (b == ESC_BYTE) nxt = P_ESC;
                    end
                endcase
            end
            if (nxt != P_IDLE) hit = 1'b0;
            pos = nxt;
            return hit;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b);
            key_result_t r;
            if (decode_byte(b, r)) begin
                expected_keys.push_back(r);
                if (r.special) begin
                    decoded++;
                    seen_keys[r.key[4:0]] = 1'b1;
                end else begin
                    raws++;
                end
            end
        endfunction

        task check_key(logic sp, logic [BYTE_W-1:0] k);
            key_result_t e;
            if (expected_keys.size() == 0) begin
                report($sformatf("key out with none pending: special=%0b index=0x%02h", sp, k));
            end else begin
                e = expected_keys.pop_front();
                if (sp !== e.special)
                    report($sformatf("is_special %0b, want %0b", sp, e.special));
                if (k !== e.key)
                    report($sformatf("key_index 0x%02h, want 0x%02h", k, e.key));
            end
        endtask
    endclass

    logic              aclk;
    logic              aresetn;
    logic              s_valid;
    logic              s_ready;
    logic [BYTE_W-1:0] s_in_byte;
    logic              m_valid;
    logic              m_ready;
    logic              m_is_special;
    logic [BYTE_W-1:0] m_key_index;

    key_scoreboard sb = new();
    bit            no_idle;
    int            bytes_sent;
    string         key_seqs[$];

    terminal_escape_key_decoder u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_is_special (m_is_special),
        .m_key_index  (m_key_index)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #2_000_000;
        $display("Timeout waiting for the decoder");
        $display("Some tests failed");
        $finish;
    end

    // Note the byte, then check the key; a key always trails the byte that completes it.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_in_byte);
            if (m_valid && m_ready) sb.check_key(m_is_special, m_key_index);
        end
    end

    task send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 7);
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_in_byte <= b;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    task send_key_seq(input string seq, input int cut, input bit broken);
        send_byte(ESC_BYTE);
        for (int i = 0; i < cut; i++) send_byte(seq[i]);
        if (broken) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver: random stall per request, one long hold-off to back up the input.
    initial begin
        int gap;
        int taken;
        m_ready = 1'b0;
        taken = 0;
        wait (aresetn === 1'b1);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 7);
            if (taken == 150) gap = 64;
            @(negedge aclk);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

    initial begin
        logic [BYTE_W-1:0] directed[$];
        int pick;
        int idx;
        int waited;
        directed = '{8'h00, 8'hFF, 8'h80, 8'h7F, "a",
                     ESC_BYTE, ESC_BYTE,
                     ESC_BYTE, "[", "A",
                     ESC_BYTE, "O", "S",
                     ESC_BYTE, "[", "1", "5", "~",
                     ESC_BYTE, "[", "5", "x",
                     ESC_BYTE, 8'hFF,
                     ESC_BYTE, "[", "[", "E"};
        key_seqs = '{"[A", "[B", "[D", "[C", "[H", "[F", "[E", "[G",
                     "[1~", "[15~", "[17~", "[18~", "[19~",
                     "[2~", "[2A", "[2B", "[2D", "[2C",
                     "[20~", "[21~", "[23~", "[24~",
                     "[3~", "[4~", "[5~", "[5A", "[5B", "[5D", "[5C", "[6~",
                     "OP", "OQ", "OR", "OS",
                     "[[A", "[[B", "[[C", "[[D", "[[E", "\033"};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_in_byte = '0;
        no_idle = 1'b0;
        bytes_sent = 0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i]) send_byte(directed[i]);

        // Mostly complete sequences, mixed with truncated ones and loose bytes.
        while (bytes_sent < 1100) begin
            no_idle = ((bytes_sent / 150) % 4) == 2;
            pick = $urandom_range(0, 99);
            idx = $urandom_range(0, key_seqs.size() - 1);
            if (pick < 60)
                send_key_seq(key_seqs[idx], key_seqs[idx].len(), 1'b0);
            else if (pick < 75)
                send_key_seq(key_seqs[idx], $urandom_range(0, key_seqs[idx].len() - 1), 1'b1);
            else
                send_byte(8'($urandom_range(0, 255)));
        end
        @(negedge aclk);
        s_valid <= 1'b0;

        waited = 0;
        while (sb.expected_keys.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (4) @(posedge aclk);
        if (sb.expected_keys.size() != 0)
            sb.report($sformatf("%0d keys never came out", sb.expected_keys.size()));

        $display("Sent %0d bytes: %0d decoded keys (%0d of 32 kinds), %0d raw bytes",
                 bytes_sent, sb.decoded, $countones(sb.seen_keys), sb.raws);
        $display("Mismatches: %0d", sb.errors);
        if (sb.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
